[rtl/ring_of_sized_entries_offset_lookup_assert.svh]
// ----------------------------------------------------------------------------
// Ring lookup assertion macros
// Concurrent assertion shorthands used at the top level.
// ----------------------------------------------------------------------------
`ifndef RING_OF_SIZED_ENTRIES_OFFSET_LOOKUP_ASSERT_SVH
`define RING_OF_SIZED_ENTRIES_OFFSET_LOOKUP_ASSERT_SVH

// same-cycle implication
`define RSOL_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsol assertion failed");

// next-cycle implication
`define RSOL_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsol assertion failed");

`endif

[rtl/rsol_pkg.sv]
// ----------------------------------------------------------------------------
// rsol_pkg
// Shared widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rsol_pkg;

	localparam int HANDLE_W = 32;
	localparam int SIZE_W   = 20;
	localparam int OFFSET_W = 24;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_FIND = 1'b1;

	typedef struct packed {
		logic load;
		logic add_rd;
		logic add_wr;
		logic find_step;
		logic find_end;
	} cmd_t;

	typedef struct packed {
		logic find_done;
	} status_t;

endpackage

[rtl/ring_of_sized_entries_offset_lookup.sv]
// ----------------------------------------------------------------------------
// ring_of_sized_entries_offset_lookup
// Overwriting ring of DEPTH sized entries with lookup by character offset.
// ----------------------------------------------------------------------------
// One operation at a time: start is taken while busy is low, and the result
// appears for one cycle with done high; it must be captured then, there is no
// back-pressure. An add does one RAM read of the slot being replaced, then
// the write. A find walks up to DEPTH slots from the oldest through the
// single RAM read port, one slot per cycle, and stops at the covering slot.
// busy drops in the done cycle, so the next transfer can be taken then.
// ----------------------------------------------------------------------------
`include "ring_of_sized_entries_offset_lookup_assert.svh"

module ring_of_sized_entries_offset_lookup #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic [rsol_pkg::HANDLE_W-1:0]   entry_handle,
	input  logic [rsol_pkg::SIZE_W-1:0]     entry_size,
	input  logic [rsol_pkg::OFFSET_W-1:0]   stream_offset,
	output logic                            done,
	output logic                            found,
	output logic [rsol_pkg::HANDLE_W-1:0]   found_handle,
	output logic [rsol_pkg::SIZE_W-1:0]     found_size,
	output logic [rsol_pkg::SIZE_W-1:0]     byte_offset,
	output logic                            replaced_valid,
	output logic [rsol_pkg::HANDLE_W-1:0]   replaced_handle
);

	rsol_pkg::cmd_t    cmd;
	rsol_pkg::status_t status;

	rsol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	rsol_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.entry_handle   (entry_handle),
		.entry_size     (entry_size),
		.stream_offset  (stream_offset),
		.done           (done),
		.found          (found),
		.found_handle   (found_handle),
		.found_size     (found_size),
		.byte_offset    (byte_offset),
		.replaced_valid (replaced_valid),
		.replaced_handle(replaced_handle)
	);

	`RSOL_AST_IMP(a_done_idle, done, !busy)
	`RSOL_AST_NXT(a_start_busy, start && !busy, busy)
	`RSOL_AST_IMP(a_one_kind, done, !(found && replaced_valid))
	`RSOL_AST_IMP(a_offset_in_slot, done && found, byte_offset < found_size)

endmodule

[rtl/rsol_ram.sv]
// ----------------------------------------------------------------------------
// rsol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/rsol_ctrl.sv]
// ----------------------------------------------------------------------------
// rsol_ctrl
// Sequencer for add and find operations.
// ----------------------------------------------------------------------------
module rsol_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  rsol_pkg::status_t status,
	output rsol_pkg::cmd_t    cmd,
	output logic              busy
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ADD_RD = 2'd1;
	localparam logic [1:0] S_ADD_WR = 2'd2;
	localparam logic [1:0] S_FIND   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (operation == rsol_pkg::OP_FIND) ? S_FIND : S_ADD_RD;
				end
			end
			S_ADD_RD: begin
				cmd.add_rd = 1'b1;
				state_d    = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_FIND: begin
				cmd.find_step = 1'b1;
				if (status.find_done) begin
					cmd.find_end = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/rsol_dp.sv]
// ----------------------------------------------------------------------------
// rsol_dp
// Ring storage, indices, offset walk and result registers.
// ----------------------------------------------------------------------------
module rsol_dp #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rsol_pkg::cmd_t                  cmd,
	output rsol_pkg::status_t               status,
	input  logic [rsol_pkg::HANDLE_W-1:0]   entry_handle,
	input  logic [rsol_pkg::SIZE_W-1:0]     entry_size,
	input  logic [rsol_pkg::OFFSET_W-1:0]   stream_offset,
	output logic                            done,
	output logic                            found,
	output logic [rsol_pkg::HANDLE_W-1:0]   found_handle,
	output logic [rsol_pkg::SIZE_W-1:0]     found_size,
	output logic [rsol_pkg::SIZE_W-1:0]     byte_offset,
	output logic                            replaced_valid,
	output logic [rsol_pkg::HANDLE_W-1:0]   replaced_handle
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = rsol_pkg::HANDLE_W + rsol_pkg::SIZE_W;

	logic [IW-1:0]                   wr_idx_q;
	logic [IW-1:0]                   old_idx_q;
	logic                            full_q;
	logic [DEPTH-1:0]                valid_q;
	logic [rsol_pkg::HANDLE_W-1:0]   hd_q;
	logic [rsol_pkg::SIZE_W-1:0]     sz_q;
	logic [rsol_pkg::OFFSET_W-1:0]   rem_q;
	logic [IW-1:0]                   pos_q;
	logic [CW-1:0]                   iss_q;
	logic [CW-1:0]                   chk_q;
	logic                            v_s1;
	logic [IW-1:0]                   pos_s1;
	logic                            done_q;

	logic [IW-1:0]                   raddr;
	logic [EW-1:0]                   rdata;
	logic [rsol_pkg::HANDLE_W-1:0]   rd_handle;
	logic [rsol_pkg::SIZE_W-1:0]     rd_size;
	logic [rsol_pkg::SIZE_W-1:0]     slot_size;
	logic                            hit;
	logic                            last;
	logic                            issue;
	logic [IW-1:0]                   w_next;
	logic [IW-1:0]                   o_next;

	function automatic logic [IW-1:0] nx(input logic [IW-1:0] i);
		nx = (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
	endfunction

	assign raddr     = cmd.add_rd ? wr_idx_q : pos_q;
	assign rd_handle = rdata[EW-1:rsol_pkg::SIZE_W];
	assign rd_size   = rdata[rsol_pkg::SIZE_W-1:0];
	assign slot_size = valid_q[pos_s1] ? rd_size : '0;
	assign hit       = v_s1 && (rem_q < rsol_pkg::OFFSET_W'(slot_size));
	assign last      = (chk_q == CW'(DEPTH - 1));
	assign issue     = cmd.find_step && (iss_q < CW'(DEPTH));
	assign w_next    = nx(wr_idx_q);
	assign o_next    = full_q ? nx(old_idx_q) : old_idx_q;

	assign status.find_done = v_s1 && (hit || last);

	rsol_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.add_wr),
		.waddr(wr_idx_q),
		.wdata({hd_q, sz_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			old_idx_q <= '0;
			full_q    <= 1'b0;
			valid_q   <= '0;
			pos_q     <= '0;
			iss_q     <= '0;
			chk_q     <= '0;
			v_s1      <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.add_wr | cmd.find_end;
			if (cmd.load) begin
				pos_q <= old_idx_q;
				iss_q <= '0;
				chk_q <= '0;
				v_s1  <= 1'b0;
			end else begin
				v_s1 <= issue;
				if (issue) begin
					pos_q <= nx(pos_q);
					iss_q <= iss_q + CW'(1);
				end
				if (cmd.find_step && v_s1) begin
					chk_q <= chk_q + CW'(1);
				end
			end
			if (cmd.add_wr) begin
				valid_q[wr_idx_q] <= 1'b1;
				wr_idx_q          <= w_next;
				old_idx_q         <= o_next;
				if (w_next == o_next) begin
					full_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hd_q  <= entry_handle;
			sz_q  <= entry_size;
			rem_q <= stream_offset;
		end else if (cmd.find_step && v_s1) begin
			rem_q <= rem_q - rsol_pkg::OFFSET_W'(slot_size);
		end
		pos_s1 <= pos_q;
		if (cmd.add_wr) begin
			found           <= 1'b0;
			found_handle    <= '0;
			found_size      <= '0;
			byte_offset     <= '0;
			replaced_valid  <= full_q;
			replaced_handle <= (full_q && valid_q[wr_idx_q]) ? rd_handle : '0;
		end else if (cmd.find_end) begin
			found           <= hit;
			found_handle    <= hit ? rd_handle : '0;
			found_size      <= hit ? slot_size : '0;
			byte_offset     <= hit ? rem_q[rsol_pkg::SIZE_W-1:0] : '0;
			replaced_valid  <= 1'b0;
			replaced_handle <= '0;
		end
	end

	assign done = done_q;

endmodule
